>>> rtl/core/dependence_chain_extractor_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dependence chain extractor
// ----------------------------------------------------------------------------
`ifndef DEPENDENCE_CHAIN_EXTRACTOR_MACROS_SVH
`define DEPENDENCE_CHAIN_EXTRACTOR_MACROS_SVH

// implication checked every clock, masked during reset
`define DCE_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define DCE_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/dce_pkg.sv
// ----------------------------------------------------------------------------
// dce_pkg
// Shared constants of the dependence chain extractor.
// ----------------------------------------------------------------------------
`default_nettype none
package dce_pkg;
    localparam int RING_DEPTH  = 64;
    localparam int REG_COUNT   = 64;
    localparam int MAX_CHAIN   = 16;
    localparam int MAX_SOURCES = 3;
    localparam int MAX_DESTS   = 2;

    localparam int RING_AW  = $clog2(RING_DEPTH);
    localparam int REG_AW   = $clog2(REG_COUNT);
    localparam int CHAIN_AW = (MAX_CHAIN > 1) ? $clog2(MAX_CHAIN) : 1;
    localparam int CNT_W    = $clog2(MAX_CHAIN + 1);
    localparam int STEP_W   = $clog2(RING_DEPTH + 1);
    localparam int REGW_W   = 45;
    localparam int RING_W   = 64 + 64 + REGW_W;
    localparam int CHAIN_W  = 64 + 64 + 9;

    localparam logic [1:0] KIND_PROD    = 2'd0;
    localparam logic [1:0] KIND_DONE    = 2'd1;
    localparam logic [1:0] KIND_DISCARD = 2'd2;
    localparam logic [1:0] MEM_LOAD     = 2'd1;
    localparam logic [1:0] MEM_STORE    = 2'd2;
    localparam logic       FUNC_RECORD  = 1'b0;
endpackage
`default_nettype wire

>>> rtl/core/dce_ram.sv
// ----------------------------------------------------------------------------
// dce_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module dce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> rtl/core/dependence_chain_extractor.sv
// Dependence chain extractor.
// Record transfer: each record passes through ST_REC, where s_ready is low, so a
//   new record waits for ST_IDLE. Extract transfer: the walk reads (ST_RD), then
//   examines (ST_EXAM) each ring entry and ends in ST_RD; producer transfers use
//   ST_OUT_RD and ST_OUT, the closing one ST_OUT_RD; s_ready returns at the edge that takes the last result transfer.
// Reset: control clears at once; then a clearing pass (ST_CLEAR) zeroes the
//   ring, during which s_ready stays low.
// ----------------------------------------------------------------------------
// dependence_chain_extractor
// Ring of retired instructions and backward walk over it, driven by a small
// sequencer that examines one ring entry per visit.
// ----------------------------------------------------------------------------
`default_nettype none
`include "dependence_chain_extractor_macros.svh"
module dependence_chain_extractor
    import dce_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_func,
    input  wire logic [63:0] s_pc,
    input  wire logic [1:0]  s_mem_type,
    input  wire logic [63:0] s_mem_addr,
    input  wire logic [1:0]  s_num_sources,
    input  wire logic [7:0]  s_src_a,
    input  wire logic [7:0]  s_src_b,
    input  wire logic [7:0]  s_src_c,
    input  wire logic [1:0]  s_num_dests,
    input  wire logic [7:0]  s_dest_a,
    input  wire logic [7:0]  s_dest_b,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_kind,
    output logic [63:0]      m_pc_res,
    output logic [7:0]       m_hit_reg,
    output logic             m_is_load,
    output logic [63:0]      m_mem_addr_res,
    output logic [4:0]       m_chain_len,
    output logic             m_last
);
    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_REC, ST_RD, ST_EXAM, ST_OUT_RD, ST_OUT, ST_DONE
    } state_t;

    state_t               state_reg;
    logic [RING_AW-1:0]   head_reg, idx_reg, clr_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [REG_COUNT-1:0] live_reg;
    logic [CNT_W-1:0]     count_reg, out_reg;
    logic [63:0]          bpc_reg;

    // ring write port: record or clearing pass
    logic                 ring_we;
    logic [RING_AW-1:0]   ring_waddr, ring_raddr;
    logic [RING_W-1:0]    ring_wdata, ring_rdata;
    logic [REGW_W-1:0]    rec_regs;
    logic [1:0]           nsrc_sat, ndst_sat;

    always_comb begin
        nsrc_sat = (s_num_sources > 2'(MAX_SOURCES)) ? 2'(MAX_SOURCES) : s_num_sources;
        ndst_sat = (s_num_dests > 2'(MAX_DESTS)) ? 2'(MAX_DESTS) : s_num_dests;
        rec_regs = '0;
        if (nsrc_sat > 2'd0) rec_regs[7:0]   = s_src_a;
        if (nsrc_sat > 2'd1) rec_regs[15:8]  = s_src_b;
        if (nsrc_sat > 2'd2) rec_regs[23:16] = s_src_c;
        if (ndst_sat > 2'd0) rec_regs[31:24] = s_dest_a;
        if (ndst_sat > 2'd1) rec_regs[39:32] = s_dest_b;
        rec_regs[41:40] = nsrc_sat;
        rec_regs[43:42] = ndst_sat;
        rec_regs[44]    = (s_mem_type == MEM_LOAD);
    end

    logic s_xfer;
    assign s_ready = (state_reg == ST_IDLE) && !m_valid;
    assign s_xfer  = s_valid && s_ready;

    always_comb begin
        if (state_reg == ST_CLEAR) begin
            ring_we    = 1'b1;
            ring_waddr = clr_reg;
            ring_wdata = '0;
        end else begin
            ring_we    = s_xfer && (s_func == FUNC_RECORD);
            ring_waddr = head_reg;
            ring_wdata = {s_pc,
                          ((s_mem_type == MEM_LOAD) || (s_mem_type == MEM_STORE))
                              ? s_mem_addr : 64'd0,
                          rec_regs};
        end
    end
    assign ring_raddr = idx_reg;

    dce_ram #(.WIDTH(RING_W), .DEPTH(RING_DEPTH)) u_ring (
        .aclk  (aclk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    // examine the entry just read: one dest compare unit per destination slot
    logic [63:0]          e_pc, e_addr;
    logic [REGW_W-1:0]    e_regs;
    logic [1:0]           e_ns, e_nd;
    logic                 e_prod;
    logic [7:0]           e_preg;
    logic [REG_COUNT-1:0] live_after;
    logic [7:0]           e_r;

    assign {e_pc, e_addr, e_regs} = ring_rdata;

    always_comb begin
        e_ns = (e_regs[41:40] > 2'(MAX_SOURCES)) ? 2'(MAX_SOURCES) : e_regs[41:40];
        e_nd = (e_regs[43:42] > 2'(MAX_DESTS)) ? 2'(MAX_DESTS) : e_regs[43:42];
        e_prod     = 1'b0;
        e_preg     = '0;
        live_after = live_reg;
        for (int i = 0; i < MAX_DESTS; i++) begin
            e_r = e_regs[24 + 8*i +: 8];
            if ((2'(i) < e_nd) && (e_r != 8'd0) && (int'(e_r) < REG_COUNT)) begin
                if (live_after[e_r[REG_AW-1:0]]) begin
                    e_prod = 1'b1;
                    e_preg = e_r;
                    live_after[e_r[REG_AW-1:0]] = 1'b0;
                end
            end
        end
        if (e_prod) begin
            for (int i = 0; i < MAX_SOURCES; i++) begin
                e_r = e_regs[8*i +: 8];
                if ((2'(i) < e_ns) && (int'(e_r) < REG_COUNT)) begin
                    live_after[e_r[REG_AW-1:0]] = 1'b1;
                end
            end
        end
    end

    // seed set
    logic [REG_COUNT-1:0] seed;
    always_comb begin
        seed = '0;
        if ((nsrc_sat > 2'd0) && (int'(s_src_a) < REG_COUNT))
            seed[s_src_a[REG_AW-1:0]] = 1'b1;
        if ((nsrc_sat > 2'd1) && (int'(s_src_b) < REG_COUNT))
            seed[s_src_b[REG_AW-1:0]] = 1'b1;
        if ((nsrc_sat > 2'd2) && (int'(s_src_c) < REG_COUNT))
            seed[s_src_c[REG_AW-1:0]] = 1'b1;
    end

    // chain buffer
    logic                chain_we;
    logic [CHAIN_AW-1:0] chain_raddr;
    logic [CHAIN_W-1:0]  chain_rdata;
    assign chain_we    = (state_reg == ST_EXAM) && e_prod && (count_reg < CNT_W'(MAX_CHAIN));
    assign chain_raddr = out_reg[CHAIN_AW-1:0];

    dce_ram #(.WIDTH(CHAIN_W), .DEPTH(MAX_CHAIN)) u_chain (
        .aclk  (aclk),
        .we    (chain_we),
        .waddr (count_reg[CHAIN_AW-1:0]),
        .wdata ({e_pc, e_addr, e_regs[44], e_preg}),
        .raddr (chain_raddr),
        .rdata (chain_rdata)
    );

    // sequencer: state, counters and the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            head_reg     <= '0;
            m_valid      <= 1'b0;
            count_reg    <= '0;
            out_reg      <= '0;
            live_reg     <= '0;
        end else begin
            // ST_OUT_RD retires the output register itself
            if (m_valid && m_ready && (state_reg != ST_OUT_RD)) m_valid <= 1'b0;
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == RING_AW'(RING_DEPTH - 1)) state_reg <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (s_xfer) begin
                        if (s_func == FUNC_RECORD) begin
                            head_reg  <= (head_reg == RING_AW'(RING_DEPTH - 1))
                                         ? '0 : head_reg + 1'b1;
                            state_reg <= ST_REC;
                        end else begin
                            bpc_reg   <= s_pc;
                            live_reg  <= seed;
                            count_reg <= '0;
                            step_reg  <= '0;
                            idx_reg   <= (head_reg == '0) ? RING_AW'(RING_DEPTH - 1)
                                         : head_reg - 1'b1;
                            state_reg <= ST_RD;
                        end
                    end
                end
                ST_REC: state_reg <= ST_IDLE;
                ST_RD: begin
                    if ((live_reg == '0) || (step_reg == STEP_W'(RING_DEPTH))) begin
                        out_reg   <= '0;
                        state_reg <= ST_OUT_RD;
                    end else begin
                        state_reg <= ST_EXAM;
                    end
                end
                ST_EXAM: begin
                    if (e_prod && (count_reg >= CNT_W'(MAX_CHAIN))) begin
                        m_valid        <= 1'b1;
                        m_kind         <= KIND_DISCARD;
                        m_pc_res       <= bpc_reg;
                        m_hit_reg      <= '0;
                        m_is_load      <= 1'b0;
                        m_mem_addr_res <= '0;
                        m_chain_len    <= '0;
                        m_last         <= 1'b1;
                        state_reg      <= ST_DONE;
                    end else begin
                        if (e_prod) count_reg <= count_reg + 1'b1;
                        live_reg  <= live_after;
                        step_reg  <= step_reg + 1'b1;
                        idx_reg   <= (idx_reg == '0) ? RING_AW'(RING_DEPTH - 1)
                                     : idx_reg - 1'b1;
                        state_reg <= ST_RD;
                    end
                end
                ST_OUT_RD: begin
                    if (!m_valid || m_ready) begin
                        if (out_reg == count_reg) begin
                            m_valid        <= 1'b1;
                            m_kind         <= KIND_DONE;
                            m_pc_res       <= bpc_reg;
                            m_hit_reg      <= '0;
                            m_is_load      <= 1'b0;
                            m_mem_addr_res <= '0;
                            m_chain_len    <= 5'(count_reg);
                            m_last         <= 1'b1;
                            state_reg      <= ST_DONE;
                        end else begin
                            m_valid   <= 1'b0;
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_OUT: begin
                    m_valid        <= 1'b1;
                    m_kind         <= KIND_PROD;
                    m_pc_res       <= chain_rdata[CHAIN_W-1 -: 64];
                    m_mem_addr_res <= chain_rdata[72:9];
                    m_is_load      <= chain_rdata[8];
                    m_hit_reg      <= chain_rdata[7:0];
                    m_chain_len    <= '0;
                    m_last         <= 1'b0;
                    out_reg        <= out_reg + 1'b1;
                    state_reg      <= ST_OUT_RD;
                end
                ST_DONE: state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `DCE_ASSERT_IMP(a_no_accept_busy, aclk, aresetn, state_reg != ST_IDLE, !s_ready)
    `DCE_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(MAX_CHAIN))
    `DCE_ASSERT_IMP(a_last_kind, aclk, aresetn, m_valid && (m_kind != KIND_PROD), m_last)
    `DCE_ASSERT_NXT(a_out_single, aclk, aresetn,
                    (state_reg == ST_OUT_RD) && m_valid && !m_ready, state_reg == ST_OUT_RD)
endmodule
`default_nettype wire
